// ===== design/lra_pkg.sv =====
// Package for the LIFO-reclaiming allocator.
// Holds the fixed field widths and the controller/datapath command and status types.
// No dependencies.
package lra_pkg;

    // Fixed widths of the beat fields
    localparam int REQ_W      = 10;
    localparam int OFFSET_W   = 8;
    localparam int RELEASED_W = 9;
    localparam int FREE_OUT_W = 9;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_req;   // capture the request, clear the release count
        logic pop;        // read the newest size, drop the live count
        logic add;        // add the popped size back to the free count
        logic finish;     // grant or fail, load the result registers
    } lra_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_release;   // request does not fit, or the size stack is full
        logic empty;          // no live block left
    } lra_stat_t;

endpackage

// ===== design/lifo_reclaiming_allocator.sv =====
// Each request beat goes from acceptance through the check step to its result register,
// releasing the newest blocks one at a time; each release takes a pop step and an add
// step, as the size stack RAM has a registered read. The finish step also waits while
// an earlier result is still held by out_ready low. The controller returns to idle
// after the finish step before it can accept again. A new beat is accepted once the
// controller is back to idle, even while the previous result waits for out_ready.
// Top level of the LIFO-reclaiming allocator. Depends on lra_pkg, lra_ctrl, lra_dp.
module lifo_reclaiming_allocator #(
    parameter int POOL_BYTES  = 256,
    parameter int STACK_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lra_pkg::REQ_W-1:0]           request_bytes,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                granted,
    output logic [lra_pkg::OFFSET_W-1:0]        block_offset,
    output logic [lra_pkg::RELEASED_W-1:0]      blocks_released,
    output logic [lra_pkg::FREE_OUT_W-1:0]      free_after
);

    import lra_pkg::*;

    lra_cmd_t  cmd;
    lra_stat_t stat;

    // Sequencer
    lra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Counters, size stack and results
    lra_dp #(
        .POOL_BYTES  (POOL_BYTES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .request_bytes   (request_bytes),
        .cmd             (cmd),
        .stat            (stat),
        .granted         (granted),
        .block_offset    (block_offset),
        .blocks_released (blocks_released),
        .free_after      (free_after)
    );

endmodule

// ===== design/lra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the size stack. No dependencies.
module lra_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/lra_dp.sv =====
// Datapath of the LIFO-reclaiming allocator: free count, live count, size stack
// and result registers. Depends on lra_pkg and lra_ram.
module lra_dp #(
    parameter int POOL_BYTES  = 256,
    parameter int STACK_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [lra_pkg::REQ_W-1:0]           request_bytes,
    input  lra_pkg::lra_cmd_t                   cmd,
    output lra_pkg::lra_stat_t                  stat,
    output logic                                granted,
    output logic [lra_pkg::OFFSET_W-1:0]        block_offset,
    output logic [lra_pkg::RELEASED_W-1:0]      blocks_released,
    output logic [lra_pkg::FREE_OUT_W-1:0]      free_after
);

    import lra_pkg::*;

    localparam int FW = $clog2(POOL_BYTES + 1);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [FW-1:0]     free_reg, free_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     released_reg, released_next;
    logic [REQ_W-1:0]  req_reg;
    logic [FW-1:0]     pop_data;
    logic [CW-1:0]     top_idx;
    logic [31:0]       free_w;
    logic [31:0]       req_w;
    logic [31:0]       rel_w;
    logic [31:0]       left_w;
    logic              fits;

    logic                  granted_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [RELEASED_W-1:0] released_out_reg;
    logic [FREE_OUT_W-1:0] free_out_reg;

    // Compare the request against the free count at a common width
    assign free_w = 32'(free_reg);
    assign req_w  = 32'(req_reg);
    assign left_w = free_w - req_w;
    assign rel_w  = 32'(released_reg);
    assign top_idx = count_reg - CW'(1);

    assign stat.need_release = (free_w < req_w) || (32'(count_reg) >= 32'(STACK_DEPTH));
    assign stat.empty        = (count_reg == '0);
    assign fits              = !stat.need_release;

    // Size stack
    lra_ram #(
        .WIDTH (FW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (cmd.finish && fits),
        .waddr (count_reg[AW-1:0]),
        .wdata (FW'(req_reg)),
        .raddr (top_idx[AW-1:0]),
        .rdata (pop_data)
    );

    // Next values of the allocator state
    always_comb
    begin
        free_next     = free_reg;
        count_next    = count_reg;
        released_next = released_reg;
        if (cmd.load_req)
        begin
            released_next = '0;
        end
        if (cmd.pop)
        begin
            count_next    = top_idx;
            released_next = released_reg + CW'(1);
        end
        if (cmd.add)
        begin
            free_next = FW'(free_reg + pop_data);
        end
        if (cmd.finish && fits)
        begin
            free_next  = left_w[FW-1:0];
            count_next = count_reg + CW'(1);
        end
    end

    // Hold allocator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg  <= FW'(POOL_BYTES);
            count_reg <= '0;
        end
        else
        begin
            free_reg  <= free_next;
            count_reg <= count_next;
        end
    end

    // Request and result registers
    always_ff @(posedge clk)
    begin
        released_reg <= released_next;
        if (cmd.load_req)
        begin
            req_reg <= request_bytes;
        end
        if (cmd.finish)
        begin
            granted_reg      <= fits;
            offset_reg       <= fits ? left_w[OFFSET_W-1:0] : '0;
            released_out_reg <= rel_w[RELEASED_W-1:0];
            free_out_reg     <= fits ? left_w[FREE_OUT_W-1:0] : free_w[FREE_OUT_W-1:0];
        end
    end

    assign granted         = granted_reg;
    assign block_offset    = offset_reg;
    assign blocks_released = released_out_reg;
    assign free_after      = free_out_reg;

    // Free count never exceeds the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(free_reg) <= 32'(POOL_BYTES))
        else $error("free count above pool size");

    // Live count never exceeds the stack depth
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(STACK_DEPTH))
        else $error("live count above stack depth");

    // Pop only when a live block exists
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !stat.empty)
        else $error("pop on empty stack");

    // Add follows a pop
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add |-> $past(cmd.pop))
        else $error("add without pop");

endmodule

// ===== design/lra_ctrl.sv =====
// Controller of the LIFO-reclaiming allocator: sequences accept, release and finish.
// Depends on lra_pkg.
module lra_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  lra_pkg::lra_stat_t  stat,
    output lra_pkg::lra_cmd_t   cmd
);

    import lra_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ADD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Decide the next step
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.need_release && !stat.empty)
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_ADD;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // A finish never overwrites a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");

    // An accepted beat leads to the check step
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_CHECK))
        else $error("accept not followed by check");

    // A finish raises the result valid flag
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finish without valid");

endmodule
